FILE: rtl/tcw_pkg.sv
// Shared types and constants for the text console writer.
// Used by tcw_engine and text_console_writer_unit; no dependencies.
package tcw_pkg;

   // Default geometry of the console
   localparam int DEF_COLUMNS = 80;
   localparam int DEF_LINES   = 25;

   // Fixed field widths
   localparam int OP_W     = 2;
   localparam int CHAR_W   = 8;
   localparam int COLOUR_W = 4;
   localparam int IDX_W    = 11;
   localparam int ROW_OUT_W = 5;
   localparam int COL_OUT_W = 7;
   localparam int CELL_W   = CHAR_W + 2 * COLOUR_W;
   localparam int CSR_IDX_W = 1;

   // Operation codes
   localparam logic [OP_W-1:0] OP_WRITE     = 2'd0;
   localparam logic [OP_W-1:0] OP_BACKSPACE = 2'd1;
   localparam logic [OP_W-1:0] OP_READ      = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TEXT_COLOUR  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAPER_COLOUR = 1'd1;

   // Register reset values
   localparam logic [COLOUR_W-1:0] TEXT_COLOUR_RST  = 4'd2;
   localparam logic [COLOUR_W-1:0] PAPER_COLOUR_RST = 4'd0;

   // Character codes
   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
   localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;

   // Colours applied to stored characters
   typedef struct packed {
      logic [COLOUR_W-1:0] fore;
      logic [COLOUR_W-1:0] back;
   } colour_type;

   // One result transfer
   typedef struct packed {
      logic [CHAR_W-1:0]    cell_char;
      logic [COLOUR_W-1:0]  cell_fore;
      logic [COLOUR_W-1:0]  cell_back;
      logic [ROW_OUT_W-1:0] cursor_row;
      logic [COL_OUT_W-1:0] cursor_column;
   } rsp_type;

endpackage

FILE: rtl/tcw_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, then register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/tcw_engine.sv
// Console sequencer: cursor, cell store access, scroll copy and reset sweep.
// Depends on tcw_pkg and tcw_ram.
module tcw_engine #(
   parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
   parameter int LINES   = tcw_pkg::DEF_LINES
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [tcw_pkg::OP_W-1:0]     req_op,
   input  logic [tcw_pkg::CHAR_W-1:0]   req_char_code,
   input  logic [tcw_pkg::IDX_W-1:0]    req_cell_index,
   input  tcw_pkg::colour_type          colour,
   output logic                         res_valid,
   input  logic                         res_take,
   output tcw_pkg::rsp_type             res
);
   import tcw_pkg::*;

   localparam int CELLS  = COLUMNS * LINES;
   localparam int SHIFT  = COLUMNS * (LINES - 1);
   localparam int ADDR_W = $clog2(CELLS);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ROW_W  = $clog2(LINES);
   localparam int CMP_W  = 16;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_SCROLL, ST_POST, ST_RDWAIT, ST_DONE
   } state_type;

   state_type            state_ff;
   logic [ROW_W-1:0]     row_ff;
   logic [COL_W-1:0]     col_ff;
   logic [ADDR_W-1:0]    base_ff;
   logic [ADDR_W-1:0]    cnt_ff;
   logic [ADDR_W-1:0]    scr_wr_ff;
   logic                 scr_wen_ff;
   logic                 pend_put_ff;
   logic [CHAR_W-1:0]    pend_char_ff;
   logic [CELL_W-1:0]    cell_ff;

   logic                 accept;
   logic                 last_row;
   logic                 col_last;
   logic [ADDR_W-1:0]    base_next;
   logic [CMP_W-1:0]     idx_ext;
   logic                 idx_ok;
   logic [CELL_W-1:0]    char_cell;
   logic [CELL_W-1:0]    space_cell;

   logic                 mem_wr_en;
   logic [ADDR_W-1:0]    mem_wr_addr;
   logic [CELL_W-1:0]    mem_wr_data;
   logic [ADDR_W-1:0]    mem_rd_addr;
   logic [CELL_W-1:0]    mem_rd_data;

   logic [ROW_W+ROW_OUT_W-1:0] row_ext;
   logic [COL_W+COL_OUT_W-1:0] col_ext;

   // Decode the request against the cursor
   assign accept     = req_valid && (state_ff == ST_IDLE);
   assign req_stall  = (state_ff != ST_IDLE);
   assign last_row   = (row_ff == ROW_W'(LINES - 1));
   assign col_last   = (col_ff == COL_W'(COLUMNS - 1));
   assign base_next  = base_ff + ADDR_W'(COLUMNS);
   assign idx_ext    = CMP_W'(req_cell_index);
   assign idx_ok     = (idx_ext < CMP_W'(CELLS));
   assign char_cell  = {colour.back, colour.fore, req_char_code};
   assign space_cell = {colour.back, colour.fore, SPACE_CODE};

   // Steer the cell store ports
   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = base_ff + ADDR_W'(col_ff);
      mem_wr_data = char_cell;
      mem_rd_addr = idx_ext[ADDR_W-1:0];
      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = cnt_ff;
            mem_wr_data = '0;
         end
         ST_IDLE: begin
            if (accept && req_op == OP_WRITE && req_char_code != NEWLINE_CODE) begin
               if (!col_last) begin
                  mem_wr_en = 1'b1;
               end else if (!last_row) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = base_next;
               end
            end else if (accept && req_op == OP_BACKSPACE && col_ff != '0) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = base_ff + ADDR_W'(col_ff - COL_W'(1));
               mem_wr_data = space_cell;
            end
         end
         ST_SCROLL: begin
            mem_rd_addr = cnt_ff + ADDR_W'(COLUMNS);
            mem_wr_en   = scr_wen_ff;
            mem_wr_addr = scr_wr_ff;
            mem_wr_data = mem_rd_data;
         end
         ST_POST: begin
            mem_wr_en   = pend_put_ff;
            mem_wr_addr = base_ff;
            mem_wr_data = {colour.back, colour.fore, pend_char_ff};
         end
         ST_RDWAIT, ST_DONE: begin
            mem_wr_en = 1'b0;
         end
         default: begin
            mem_wr_en = 1'b0;
         end
      endcase
   end

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Sequence each item, the scroll copy and the reset sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         row_ff      <= '0;
         col_ff      <= '0;
         base_ff     <= '0;
         cnt_ff      <= '0;
         scr_wen_ff  <= 1'b0;
         pend_put_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_CLEAR: begin
               if (cnt_ff == ADDR_W'(CELLS - 1)) begin
                  state_ff <= ST_IDLE;
               end
               cnt_ff <= cnt_ff + ADDR_W'(1);
            end
            ST_IDLE: begin
               if (accept) begin
                  cell_ff    <= '0;
                  cnt_ff     <= '0;
                  scr_wen_ff <= 1'b0;
                  state_ff   <= ST_DONE;
                  case (req_op)
                     OP_WRITE: begin
                        if (req_char_code == NEWLINE_CODE || col_last) begin
                           pend_put_ff  <= (req_char_code != NEWLINE_CODE);
                           pend_char_ff <= req_char_code;
                           if (last_row) begin
                              state_ff <= ST_SCROLL;
                           end else begin
                              row_ff  <= row_ff + ROW_W'(1);
                              base_ff <= base_next;
                              col_ff  <= (req_char_code == NEWLINE_CODE) ?
                                         COL_W'(0) : COL_W'(1);
                           end
                        end else begin
                           col_ff <= col_ff + COL_W'(1);
                        end
                     end
                     OP_BACKSPACE: begin
                        if (col_ff != '0) begin
                           col_ff <= col_ff - COL_W'(1);
                        end
                     end
                     OP_READ: begin
                        if (idx_ok) begin
                           state_ff <= ST_RDWAIT;
                        end
                     end
                     default: begin
                        state_ff <= ST_DONE;
                     end
                  endcase
               end
            end
            ST_SCROLL: begin
               // Read one cell a line below, write the previous one up
               if (cnt_ff != ADDR_W'(SHIFT)) begin
                  scr_wr_ff  <= cnt_ff;
                  scr_wen_ff <= 1'b1;
                  cnt_ff     <= cnt_ff + ADDR_W'(1);
               end else begin
                  scr_wen_ff <= 1'b0;
                  state_ff   <= ST_POST;
               end
            end
            ST_POST: begin
               col_ff   <= pend_put_ff ? COL_W'(1) : COL_W'(0);
               state_ff <= ST_DONE;
            end
            ST_RDWAIT: begin
               cell_ff  <= mem_rd_data;
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (res_take) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Present the result with the cursor masked to the field widths
   assign row_ext   = {{ROW_OUT_W{1'b0}}, row_ff};
   assign col_ext   = {{COL_OUT_W{1'b0}}, col_ff};
   assign res_valid = (state_ff == ST_DONE);

   always_comb begin
      res.cell_char     = cell_ff[CHAR_W-1:0];
      res.cell_fore     = cell_ff[CHAR_W+COLOUR_W-1:CHAR_W];
      res.cell_back     = cell_ff[CELL_W-1:CHAR_W+COLOUR_W];
      res.cursor_row    = row_ext[ROW_OUT_W-1:0];
      res.cursor_column = col_ext[COL_OUT_W-1:0];
   end

endmodule

FILE: rtl/text_console_writer_unit.sv
// Text console writer: a LINES by COLUMNS cell store with cursor, scroll and
// backspace. Every cell store access goes through one write port and one read
// port of a single RAM, and that port sets the timing. A read inside the store
// passes through a wait state for the registered RAM word; a character write,
// newline, backspace, unused op or read outside the store goes straight to its
// result. A newline on the last line (explicit, or forced by a character at
// the last column) copies the store up one line, one cell a cycle. After reset
// the store is swept to zero before the first item is accepted; colour writes
// are taken at any time. A finished result waits in an output register, so the
// next item is accepted while it is held.
// Depends on tcw_pkg and tcw_engine.
module text_console_writer_unit #(
   parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
   parameter int LINES   = tcw_pkg::DEF_LINES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [tcw_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tcw_pkg::COLOUR_W-1:0]    csr_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [tcw_pkg::OP_W-1:0]        req_op,
   input  logic [tcw_pkg::CHAR_W-1:0]      req_char_code,
   input  logic [tcw_pkg::IDX_W-1:0]       req_cell_index,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [tcw_pkg::CHAR_W-1:0]      rsp_cell_char,
   output logic [tcw_pkg::COLOUR_W-1:0]    rsp_cell_fore,
   output logic [tcw_pkg::COLOUR_W-1:0]    rsp_cell_back,
   output logic [tcw_pkg::ROW_OUT_W-1:0]   rsp_cursor_row,
   output logic [tcw_pkg::COL_OUT_W-1:0]   rsp_cursor_column
);
   import tcw_pkg::*;

   logic [COLOUR_W-1:0] text_colour_ff;
   logic [COLOUR_W-1:0] paper_colour_ff;
   colour_type          colour;
   logic                res_valid;
   logic                res_take;
   rsp_type             res;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;

   // Hold the colour registers
   always_ff @(posedge clock) begin
      if (reset) begin
         text_colour_ff  <= TEXT_COLOUR_RST;
         paper_colour_ff <= PAPER_COLOUR_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TEXT_COLOUR:  text_colour_ff  <= csr_data;
            CSR_PAPER_COLOUR: paper_colour_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign colour.fore = text_colour_ff;
   assign colour.back = paper_colour_ff;

   tcw_engine #(
      .COLUMNS (COLUMNS),
      .LINES   (LINES)
   ) u_engine (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_char_code  (req_char_code),
      .req_cell_index (req_cell_index),
      .colour         (colour),
      .res_valid      (res_valid),
      .res_take       (res_take),
      .res            (res)
   );

   // Load the output register when it is empty or its transfer completes
   assign res_take = res_valid && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cell_char     = rsp_ff.cell_char;
   assign rsp_cell_fore     = rsp_ff.cell_fore;
   assign rsp_cell_back     = rsp_ff.cell_back;
   assign rsp_cursor_row    = rsp_ff.cursor_row;
   assign rsp_cursor_column = rsp_ff.cursor_column;

endmodule
